[src/slotted_contention_round_macros.svh]
// ============================================================================
// slotted_contention_round_macros.svh
// Assertion macros shared by the slotted contention round RTL.
// ============================================================================
`ifndef SLOTTED_CONTENTION_ROUND_MACROS_SVH
`define SLOTTED_CONTENTION_ROUND_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scr assertion failed");
// next-cycle implication
`define SCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scr assertion failed");
`else
`define SCR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/scr_pkg.sv]
// ============================================================================
// scr_pkg
// Types, codes and helpers for the slotted contention round block.
// ============================================================================
package scr_pkg;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int RND_W      = 16;
    localparam int CNT16_W    = 16;
    localparam int CNT32_W    = 32;
    localparam int SUCC_W     = 9;

    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = RND_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_ATTEMPT   = 2'd0;
    localparam logic [1:0] CMD_END_ROUND = 2'd1;
    localparam logic [1:0] CMD_RESTART   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 9'd16;
    localparam logic [CFG_W-1:0] NODE_COUNT_RST  = 9'd16;

    // slot store codes
    localparam int SLOT_EMPTY      = 0;
    localparam int SLOT_COLLIDED   = 1;
    localparam int SLOT_OWNER_BASE = 2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       node_id;
        logic [RND_W-1:0] random_value;
    } scr_in_t;

    typedef struct packed {
        logic [7:0]         slot_taken;
        logic               collided;
        logic               skipped;
        logic [SUCC_W-1:0]  round_successes;
        logic               all_sent;
        logic [CNT32_W-1:0] round_number;
        logic [CNT32_W-1:0] conflict_total;
        logic [CNT32_W-1:0] energy_total;
        logic [CNT16_W-1:0] node_conflicts;
    } scr_out_t;

    typedef struct packed {
        logic               sent;
        logic [CNT16_W-1:0] energy;
        logic [CNT16_W-1:0] conflicts;
    } scr_node_t;

    typedef struct packed {
        logic clear;
        logic round_inc;
        logic energy_inc;
        logic conflict_inc;
    } scr_stat_ev_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NODE_RD,
        S_DIV,
        S_SLOT_RD,
        S_WALK_SLOT,
        S_WALK_NODE,
        S_FIND_RD,
        S_FIND
    } scr_state_t;

    function automatic logic [CNT16_W-1:0] sat_inc16(input logic [CNT16_W-1:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    function automatic logic [CNT32_W-1:0] sat_inc32(input logic [CNT32_W-1:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

endpackage

[src/slotted_contention_round.sv]
// ============================================================================
// slotted_contention_round
// Framed slotted ALOHA slot arbiter with a configurable contention window.
// ============================================================================
// Usage:
//   A transaction is taken when start is high and busy is low. request.cmd
//   selects a node attempt, an end of round or a restart. Every transaction
//   gives one result on the result port, marked by a one-cycle done strobe;
//   the receiver cannot stall, so results must be taken when done is high.
//   Attempts: from accept to done a node read, the modulo unit and a slot
//   read-modify-write; a skipped attempt ends at the node range check or
//   at the node read, and an unused command gives done with no other step.
//   End of round: walks all MAX_SLOTS slot entries, reading the owner node
//   of each owned slot and marking it sent, then scans the node table for
//   the first unsent node until it finds one or the scan runs off the end
//   of the node table.
//   Restart: a clearing pass over max(MAX_NODES, MAX_SLOTS) entries, then done.
//   A new transaction may be accepted in the cycle its predecessor's done
//   is high. After reset the same clearing pass runs with busy high;
//   configuration writes (cfg_we, cfg_index, cfg_data) are taken at any time.
// ============================================================================
`include "slotted_contention_round_macros.svh"

module slotted_contention_round
#(
    parameter int MAX_NODES = 256,
    parameter int MAX_SLOTS = 256
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  scr_pkg::scr_in_t                request,
    output logic                            done,
    output scr_pkg::scr_out_t               result,
    input  logic                            cfg_we,
    input  logic [scr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int SW    = $clog2(MAX_SLOTS);
    localparam int CW    = $clog2(MAX_NODES + 2);
    localparam int FW    = $clog2(MAX_NODES + 1);
    localparam int CLR_N = (MAX_NODES > MAX_SLOTS) ? MAX_NODES : MAX_SLOTS;
    localparam int CLRW  = $clog2(CLR_N);

    // configuration
    logic [scr_pkg::CFG_W-1:0] window_size_reg;
    logic [scr_pkg::CFG_W-1:0] node_count_reg;
    logic [scr_pkg::CFG_W-1:0] eff_window;
    logic [scr_pkg::CFG_W-1:0] eff_nodes;

    // memories
    scr_pkg::scr_node_t node_mem [MAX_NODES];
    scr_pkg::scr_node_t node_rdata_reg;
    logic [NW-1:0]      node_raddr;
    logic               node_we;
    logic [NW-1:0]      node_waddr;
    scr_pkg::scr_node_t node_wdata;

    logic [CW-1:0]      slot_mem [MAX_SLOTS];
    logic [CW-1:0]      slot_rdata_reg;
    logic [SW-1:0]      slot_raddr;
    logic               slot_we;
    logic [SW-1:0]      slot_waddr;
    logic [CW-1:0]      slot_wdata;

    // control
    scr_pkg::scr_state_t state_reg, state_next;
    logic [CLRW-1:0]     clr_idx_reg, clr_idx_next;
    logic                restart_pend_reg, restart_pend_next;
    logic [SW-1:0]       walk_idx_reg, walk_idx_next;
    logic [NW-1:0]       owner_reg, owner_next;
    logic [FW-1:0]       first_unsent_reg, first_unsent_next;
    logic [scr_pkg::SUCC_W-1:0] succ_reg, succ_next;
    scr_pkg::scr_node_t  node_reg, node_next;
    logic [NW-1:0]       node_idx_reg, node_idx_next;
    logic [SW-1:0]       slot_idx_reg, slot_idx_next;

    // result
    logic                        done_reg, done_next;
    logic [7:0]                  res_slot_reg, res_slot_next;
    logic                        res_coll_reg, res_coll_next;
    logic                        res_skip_reg, res_skip_next;
    logic [scr_pkg::SUCC_W-1:0]  res_succ_reg, res_succ_next;
    logic [scr_pkg::CNT16_W-1:0] res_nconf_reg, res_nconf_next;

    // modulo unit and stats
    logic                        div_start;
    logic                        div_done;
    logic [scr_pkg::CFG_W-1:0]   div_rem;
    scr_pkg::scr_stat_ev_t       stat_ev;
    logic [scr_pkg::CNT32_W-1:0] round_number;
    logic [scr_pkg::CNT32_W-1:0] conflict_total;
    logic [scr_pkg::CNT32_W-1:0] energy_total;

    logic                        accept;
    logic                        node_in_range;
    logic                        walk_step;
    logic                        coll;
    logic [CW-1:0]               code;
    logic [CW-1:0]               owner_code;
    logic [scr_pkg::CNT16_W-1:0] new_conf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= scr_pkg::WINDOW_SIZE_RST;
            node_count_reg  <= scr_pkg::NODE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scr_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                scr_pkg::REG_NODE_COUNT:  node_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (window_size_reg == '0)
            eff_window = scr_pkg::CFG_W'(1);
        else if (32'(window_size_reg) > MAX_SLOTS)
            eff_window = scr_pkg::CFG_W'(MAX_SLOTS);
        else
            eff_window = window_size_reg;

        if (node_count_reg == '0)
            eff_nodes = scr_pkg::CFG_W'(1);
        else if (32'(node_count_reg) > MAX_NODES)
            eff_nodes = scr_pkg::CFG_W'(MAX_NODES);
        else
            eff_nodes = node_count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    scr_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (request.random_value),
        .divisor   (eff_window),
        .done      (div_done),
        .remainder (div_rem)
    );

    scr_stats u_stats
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ev             (stat_ev),
        .round_number   (round_number),
        .conflict_total (conflict_total),
        .energy_total   (energy_total)
    );

    assign accept        = start && (state_reg == scr_pkg::S_IDLE);
    assign node_in_range = ({1'b0, request.node_id} < eff_nodes)
                           && (32'(request.node_id) < MAX_NODES);
    assign code          = slot_rdata_reg;
    assign owner_code    = code - CW'(scr_pkg::SLOT_OWNER_BASE);
    assign coll          = (slot_rdata_reg != CW'(scr_pkg::SLOT_EMPTY));
    assign new_conf      = coll ? scr_pkg::sat_inc16(node_reg.conflicts) : node_reg.conflicts;

    always_comb
    begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        restart_pend_next = restart_pend_reg;
        walk_idx_next     = walk_idx_reg;
        owner_next        = owner_reg;
        first_unsent_next = first_unsent_reg;
        succ_next         = succ_reg;
        node_next         = node_reg;
        node_idx_next     = node_idx_reg;
        slot_idx_next     = slot_idx_reg;

        done_next         = 1'b0;
        res_slot_next     = res_slot_reg;
        res_coll_next     = res_coll_reg;
        res_skip_next     = res_skip_reg;
        res_succ_next     = res_succ_reg;
        res_nconf_next    = res_nconf_reg;

        node_raddr = '0;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        slot_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        div_start  = 1'b0;
        stat_ev    = '0;
        walk_step  = 1'b0;

        unique case (state_reg)
            scr_pkg::S_CLEAR:
            begin
                slot_we    = (32'(clr_idx_reg) < MAX_SLOTS);
                slot_waddr = SW'(clr_idx_reg);
                slot_wdata = CW'(scr_pkg::SLOT_EMPTY);
                node_we    = (32'(clr_idx_reg) < MAX_NODES);
                node_waddr = NW'(clr_idx_reg);
                node_wdata = '0;
                if (clr_idx_reg == CLRW'(CLR_N - 1))
                begin
                    state_next = scr_pkg::S_IDLE;
                    if (restart_pend_reg)
                    begin
                        restart_pend_next = 1'b0;
                        done_next         = 1'b1;
                        res_slot_next     = '0;
                        res_coll_next     = 1'b0;
                        res_skip_next     = 1'b0;
                        res_succ_next     = '0;
                        res_nconf_next    = '0;
                    end
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end

            scr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_slot_next  = '0;
                    res_coll_next  = 1'b0;
                    res_skip_next  = 1'b0;
                    res_succ_next  = '0;
                    res_nconf_next = '0;
                    case (request.cmd)
                        scr_pkg::CMD_ATTEMPT:
                        begin
                            if (node_in_range)
                            begin
                                node_raddr    = NW'(request.node_id);
                                node_idx_next = NW'(request.node_id);
                                div_start     = 1'b1;
                                state_next    = scr_pkg::S_NODE_RD;
                            end
                            else
                            begin
                                done_next     = 1'b1;
                                res_skip_next = 1'b1;
                            end
                        end
                        scr_pkg::CMD_END_ROUND:
                        begin
                            walk_idx_next = '0;
                            succ_next     = '0;
                            slot_raddr    = '0;
                            state_next    = scr_pkg::S_WALK_SLOT;
                        end
                        scr_pkg::CMD_RESTART:
                        begin
                            stat_ev.clear     = 1'b1;
                            first_unsent_next = '0;
                            clr_idx_next      = '0;
                            restart_pend_next = 1'b1;
                            state_next        = scr_pkg::S_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            scr_pkg::S_NODE_RD:
            begin
                node_next = node_rdata_reg;
                if (node_rdata_reg.sent)
                begin
                    done_next      = 1'b1;
                    res_skip_next  = 1'b1;
                    res_nconf_next = node_rdata_reg.conflicts;
                    state_next     = scr_pkg::S_IDLE;
                end
                else
                begin
                    state_next = scr_pkg::S_DIV;
                end
            end

            scr_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    slot_raddr    = SW'(div_rem);
                    slot_idx_next = SW'(div_rem);
                    state_next    = scr_pkg::S_SLOT_RD;
                end
            end

            scr_pkg::S_SLOT_RD:
            begin
                slot_we    = 1'b1;
                slot_waddr = slot_idx_reg;
                slot_wdata = coll ? CW'(scr_pkg::SLOT_COLLIDED)
                                  : CW'(node_idx_reg) + CW'(scr_pkg::SLOT_OWNER_BASE);
                node_we    = 1'b1;
                node_waddr = node_idx_reg;
                node_wdata.sent      = node_reg.sent;
                node_wdata.energy    = scr_pkg::sat_inc16(node_reg.energy);
                node_wdata.conflicts = new_conf;
                stat_ev.energy_inc   = 1'b1;
                stat_ev.conflict_inc = coll;
                done_next      = 1'b1;
                res_slot_next  = 8'(slot_idx_reg);
                res_coll_next  = coll;
                res_nconf_next = new_conf;
                state_next     = scr_pkg::S_IDLE;
            end

            scr_pkg::S_WALK_SLOT:
            begin
                slot_we    = 1'b1;
                slot_waddr = walk_idx_reg;
                slot_wdata = CW'(scr_pkg::SLOT_EMPTY);
                if (code >= CW'(scr_pkg::SLOT_OWNER_BASE) && 32'(owner_code) < MAX_NODES)
                begin
                    node_raddr = NW'(owner_code);
                    owner_next = NW'(owner_code);
                    state_next = scr_pkg::S_WALK_NODE;
                end
                else
                begin
                    walk_step = 1'b1;
                end
            end

            scr_pkg::S_WALK_NODE:
            begin
                if (!node_rdata_reg.sent)
                begin
                    node_we         = 1'b1;
                    node_waddr      = owner_reg;
                    node_wdata      = node_rdata_reg;
                    node_wdata.sent = 1'b1;
                    if (!(&succ_reg))
                    begin
                        succ_next = succ_reg + 1'b1;
                    end
                end
                walk_step = 1'b1;
            end

            scr_pkg::S_FIND_RD:
            begin
                if (32'(first_unsent_reg) < MAX_NODES)
                begin
                    node_raddr = NW'(first_unsent_reg);
                    state_next = scr_pkg::S_FIND;
                end
                else
                begin
                    done_next     = 1'b1;
                    res_succ_next = succ_reg;
                    state_next    = scr_pkg::S_IDLE;
                end
            end

            scr_pkg::S_FIND:
            begin
                if (node_rdata_reg.sent)
                begin
                    first_unsent_next = first_unsent_reg + 1'b1;
                    if (32'(first_unsent_reg) + 1 < MAX_NODES)
                    begin
                        node_raddr = NW'(first_unsent_next);
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        res_succ_next = succ_reg;
                        state_next    = scr_pkg::S_IDLE;
                    end
                end
                else
                begin
                    done_next     = 1'b1;
                    res_succ_next = succ_reg;
                    state_next    = scr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = scr_pkg::S_IDLE;
            end
        endcase

        // advance the end-of-round walk
        if (walk_step)
        begin
            if (walk_idx_reg == SW'(MAX_SLOTS - 1))
            begin
                stat_ev.round_inc = 1'b1;
                state_next        = scr_pkg::S_FIND_RD;
            end
            else
            begin
                walk_idx_next = walk_idx_reg + 1'b1;
                slot_raddr    = walk_idx_reg + 1'b1;
                state_next    = scr_pkg::S_WALK_SLOT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= scr_pkg::S_CLEAR;
            clr_idx_reg      <= '0;
            restart_pend_reg <= 1'b0;
            walk_idx_reg     <= '0;
            first_unsent_reg <= '0;
            succ_reg         <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            restart_pend_reg <= restart_pend_next;
            walk_idx_reg     <= walk_idx_next;
            first_unsent_reg <= first_unsent_next;
            succ_reg         <= succ_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg     <= owner_next;
        node_reg      <= node_next;
        node_idx_reg  <= node_idx_next;
        slot_idx_reg  <= slot_idx_next;
        res_slot_reg  <= res_slot_next;
        res_coll_reg  <= res_coll_next;
        res_skip_reg  <= res_skip_next;
        res_succ_reg  <= res_succ_next;
        res_nconf_reg <= res_nconf_next;
    end

    assign busy = (state_reg != scr_pkg::S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        result.slot_taken      = res_slot_reg;
        result.collided        = res_coll_reg;
        result.skipped         = res_skip_reg;
        result.round_successes = res_succ_reg;
        result.all_sent        = (32'(first_unsent_reg) >= 32'(eff_nodes));
        result.round_number    = round_number;
        result.conflict_total  = conflict_total;
        result.energy_total    = energy_total;
        result.node_conflicts  = res_nconf_reg;
    end

    `SCR_ASSERT_NXT(a_restart_busy, clk, rst_n, accept && request.cmd == scr_pkg::CMD_RESTART, busy)
    `SCR_ASSERT_IMP(a_skip_clean, clk, rst_n, done && result.skipped, !result.collided && result.slot_taken == 8'd0)
    `SCR_ASSERT_IMP(a_coll_counted, clk, rst_n, done && result.collided, result.conflict_total != 32'd0)

endmodule

[src/scr_mod.sv]
// ============================================================================
// scr_mod
// Iterative remainder unit: random word modulo window size, four bits a cycle.
// ============================================================================
module scr_mod
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [scr_pkg::RND_W-1:0]    dividend,
    input  logic [scr_pkg::CFG_W-1:0]    divisor,
    output logic                         done,
    output logic [scr_pkg::CFG_W-1:0]    remainder
);

    logic [scr_pkg::CFG_W-1:0]     rem_reg;
    logic [scr_pkg::CFG_W-1:0]     rem_next;
    logic [scr_pkg::RND_W-1:0]     dvd_reg;
    logic [scr_pkg::CFG_W-1:0]     dsr_reg;
    logic [scr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          run_reg;
    logic                          done_reg;

    always_comb
    begin
        logic [scr_pkg::CFG_W:0] r;
        r = {1'b0, rem_reg};
        for (int i = 0; i < scr_pkg::DIV_BITS; i++)
        begin
            r = {r[scr_pkg::CFG_W-1:0], dvd_reg[scr_pkg::RND_W-1-i]};
            if (r >= {1'b0, dsr_reg})
            begin
                r = r - {1'b0, dsr_reg};
            end
        end
        rem_next = r[scr_pkg::CFG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == scr_pkg::DIV_CNT_W'(scr_pkg::DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << scr_pkg::DIV_BITS;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[src/scr_stats.sv]
// ============================================================================
// scr_stats
// Global saturating counters: round number, conflicts and energy.
// ============================================================================
`include "slotted_contention_round_macros.svh"

module scr_stats
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  scr_pkg::scr_stat_ev_t         ev,
    output logic [scr_pkg::CNT32_W-1:0]   round_number,
    output logic [scr_pkg::CNT32_W-1:0]   conflict_total,
    output logic [scr_pkg::CNT32_W-1:0]   energy_total
);

    logic [scr_pkg::CNT32_W-1:0] round_reg;
    logic [scr_pkg::CNT32_W-1:0] round_next;
    logic [scr_pkg::CNT32_W-1:0] conflict_reg;
    logic [scr_pkg::CNT32_W-1:0] conflict_next;
    logic [scr_pkg::CNT32_W-1:0] energy_reg;
    logic [scr_pkg::CNT32_W-1:0] energy_next;

    always_comb
    begin
        round_next    = round_reg;
        conflict_next = conflict_reg;
        energy_next   = energy_reg;
        if (ev.clear)
        begin
            round_next    = 32'd1;
            conflict_next = '0;
            energy_next   = '0;
        end
        else
        begin
            if (ev.round_inc)
            begin
                round_next = scr_pkg::sat_inc32(round_reg);
            end
            if (ev.conflict_inc)
            begin
                conflict_next = scr_pkg::sat_inc32(conflict_reg);
            end
            if (ev.energy_inc)
            begin
                energy_next = scr_pkg::sat_inc32(energy_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg    <= 32'd1;
            conflict_reg <= '0;
            energy_reg   <= '0;
        end
        else
        begin
            round_reg    <= round_next;
            conflict_reg <= conflict_next;
            energy_reg   <= energy_next;
        end
    end

    assign round_number   = round_reg;
    assign conflict_total = conflict_reg;
    assign energy_total   = energy_reg;

    `SCR_ASSERT_IMP(a_round_nonzero, clk, rst_n, 1'b1, round_reg != 32'd0)
    `SCR_ASSERT_NXT(a_clear_round, clk, rst_n, ev.clear, round_reg == 32'd1 && energy_reg == 32'd0)
    `SCR_ASSERT_NXT(a_energy_mono, clk, rst_n, !ev.clear, energy_reg >= $past(energy_reg))

endmodule

[dv/slotted_contention_round_tb.sv]
// ============================================================================
// slotted_contention_round_tb
// Self-checking bench for the slotted contention round arbiter. A directed
// part covers slot ownership, collisions, skipped nodes, the window-shrink
// credit at end of round, restart and register extremes. A random part then
// runs rounds of attempts under changing window and node settings. Every
// result is checked against a predictor that tracks the slot table and the
// per-node and global counters.
// ============================================================================
module slotted_contention_round_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES     = 256;
    localparam int MAX_SLOTS     = 256;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int IDLE_LIMIT    = 8000;
    localparam int SETTLE_CYCLES = 1100;
    localparam int REPORT_MAX    = 10;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          start     = 1'b0;
    logic                          busy;
    scr_pkg::scr_in_t              request   = '0;
    logic                          done;
    scr_pkg::scr_out_t             result;
    logic                          cfg_we    = 1'b0;
    logic [scr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [scr_pkg::CFG_W-1:0]     cfg_data  = '0;

    // predictor state
    logic [scr_pkg::CFG_W-1:0] window_reg;
    logic [scr_pkg::CFG_W-1:0] nodes_reg;
    logic [9:0]       slot_code [MAX_SLOTS];
    bit               node_sent [MAX_NODES];
    logic [15:0]      node_conflict_cnt [MAX_NODES];
    logic [31:0]      round_cnt;
    logic [31:0]      conflict_cnt;
    logic [31:0]      energy_cnt;

    scr_pkg::scr_out_t expected_outcomes [$];
    int       fault_cnt   = 0;
    int       idle_cycles = 0;
    int       burst_left  = 0;
    bit       pacing_on   = 1'b1;

    slotted_contention_round #(
        .MAX_NODES(MAX_NODES),
        .MAX_SLOTS(MAX_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_window();
        if (window_reg == 0)
            return 1;
        if (window_reg > MAX_SLOTS)
            return MAX_SLOTS;
        return int'(window_reg);
    endfunction

    function automatic int eff_nodes();
        if (nodes_reg == 0)
            return 1;
        if (nodes_reg > MAX_NODES)
            return MAX_NODES;
        return int'(nodes_reg);
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [31:0] bump32(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < MAX_SLOTS; i++)
            slot_code[i] = scr_pkg::SLOT_EMPTY;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            node_sent[i]         = 1'b0;
            node_conflict_cnt[i] = '0;
        end
        round_cnt    = 32'd1;
        conflict_cnt = '0;
        energy_cnt   = '0;
    endfunction

    function automatic bit every_node_sent();
        for (int i = 0; i < eff_nodes(); i++)
            if (!node_sent[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic scr_pkg::scr_out_t predict_outcome(input scr_pkg::scr_in_t req);
        scr_pkg::scr_out_t o;
        int         n;
        int         s;
        int         owner;
        logic [8:0] succ;
        o    = '0;
        n    = int'(req.node_id);
        succ = '0;
        case (req.cmd)
            scr_pkg::CMD_ATTEMPT:
            begin
                if (n >= eff_nodes())
                    o.skipped = 1'b1;
                else if (node_sent[n])
                begin
                    o.skipped        = 1'b1;
                    o.node_conflicts = node_conflict_cnt[n];
                end
                else
                begin
                    s            = int'(req.random_value % eff_window());
                    o.slot_taken = s[7:0];
                    energy_cnt   = bump32(energy_cnt);
                    if (slot_code[s] != scr_pkg::SLOT_EMPTY)
                    begin
                        o.collided           = 1'b1;
                        slot_code[s]         = scr_pkg::SLOT_COLLIDED;
                        node_conflict_cnt[n] = bump16(node_conflict_cnt[n]);
                        conflict_cnt         = bump32(conflict_cnt);
                    end
                    else
                        slot_code[s] = 10'(n + scr_pkg::SLOT_OWNER_BASE);
                    o.node_conflicts = node_conflict_cnt[n];
                end
            end
            scr_pkg::CMD_END_ROUND:
            begin
                // whole store is walked, including slots beyond a shrunk window
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (slot_code[i] >= scr_pkg::SLOT_OWNER_BASE)
                    begin
                        owner = int'(slot_code[i]) - scr_pkg::SLOT_OWNER_BASE;
                        if (owner < MAX_NODES && !node_sent[owner])
                        begin
                            node_sent[owner] = 1'b1;
                            if (succ != 9'h1FF)
                                succ = succ + 9'd1;
                        end
                    end
                    slot_code[i] = scr_pkg::SLOT_EMPTY;
                end
                round_cnt = bump32(round_cnt);
            end
            scr_pkg::CMD_RESTART:
                clear_model();
            default:
                ;
        endcase
        o.round_successes = succ;
        o.all_sent        = every_node_sent();
        o.round_number    = round_cnt;
        o.conflict_total  = conflict_cnt;
        o.energy_total    = energy_cnt;
        return o;
    endfunction

    function automatic string fmt_outcome(input scr_pkg::scr_out_t o);
        return $sformatf({"slot=%0d coll=%0b skip=%0b succ=%0d all=%0b ",
                          "round=%0d conf=%0d energy=%0d nconf=%0d"},
                         o.slot_taken, o.collided, o.skipped, o.round_successes,
                         o.all_sent, o.round_number, o.conflict_total,
                         o.energy_total, o.node_conflicts);
    endfunction

    // result check, config tracking and transaction prediction
    always @(posedge clk)
    begin : monitor
        scr_pkg::scr_out_t want;
        scr_pkg::scr_out_t pred;
        if (!rst_n)
        begin
            clear_model();
            window_reg = scr_pkg::WINDOW_SIZE_RST;
            nodes_reg  = scr_pkg::NODE_COUNT_RST;
        end
        else
        begin
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    if (fault_cnt < REPORT_MAX)
                        $display("unexpected result: %s", fmt_outcome(result));
                    fault_cnt++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (result.slot_taken      !== want.slot_taken      ||
                        result.collided        !== want.collided        ||
                        result.skipped         !== want.skipped         ||
                        result.round_successes !== want.round_successes ||
                        result.all_sent        !== want.all_sent        ||
                        result.round_number    !== want.round_number    ||
                        result.conflict_total  !== want.conflict_total  ||
                        result.energy_total    !== want.energy_total    ||
                        result.node_conflicts  !== want.node_conflicts)
                    begin
                        if (fault_cnt < REPORT_MAX)
                        begin
                            $display("mismatch expected: %s", fmt_outcome(want));
                            $display("         actual:   %s", fmt_outcome(result));
                        end
                        fault_cnt++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == scr_pkg::REG_WINDOW_SIZE)
                    window_reg = cfg_data;
                if (cfg_index == scr_pkg::REG_NODE_COUNT)
                    nodes_reg = cfg_data;
            end
            if (start && !busy)
            begin
                pred              = predict_outcome(request);
                expected_outcomes = {expected_outcomes, pred};
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAIL");
        $finish;
    end

    task automatic pace_sender();
        if (pacing_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8))
                    @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
    endtask

    task automatic issue_request(input logic [1:0] op, input int node, input int rnd);
        scr_pkg::scr_in_t r;
        r.cmd          = op;
        r.node_id      = node[7:0];
        r.random_value = rnd[15:0];
        pace_sender();
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic set_config(input int win, input int nodes);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= scr_pkg::REG_WINDOW_SIZE;
        cfg_data  <= win[scr_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= scr_pkg::REG_NODE_COUNT;
        cfg_data  <= nodes[scr_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_size(input int max_v);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return max_v;
            3: return $urandom_range(max_v + 1, 511);
            4, 5, 6: return $urandom_range(2, 8);
            default: return $urandom_range(1, max_v);
        endcase
    endfunction

    task automatic test_idle_status();
        issue_request(CMD_UNUSED, 255, 16'hFFFF);
    endtask

    task automatic test_contention();
        issue_request(scr_pkg::CMD_ATTEMPT, 0, 0);
        issue_request(scr_pkg::CMD_ATTEMPT, 1, 16);
        issue_request(scr_pkg::CMD_ATTEMPT, 2, 32);          // slot already collided
        issue_request(scr_pkg::CMD_ATTEMPT, 3, 16'hFFFF);
        issue_request(scr_pkg::CMD_ATTEMPT, 255, 16'hFFFF);  // node out of range
        issue_request(scr_pkg::CMD_ATTEMPT, 15, 16'h5A5A);
        issue_request(scr_pkg::CMD_END_ROUND, 0, 0);
        issue_request(scr_pkg::CMD_ATTEMPT, 3, 7);           // node already sent
        issue_request(scr_pkg::CMD_ATTEMPT, 1, 1);
        issue_request(CMD_UNUSED, 0, 0);
        issue_request(scr_pkg::CMD_RESTART, 0, 0);
    endtask

    task automatic test_window_shrink();
        set_config(MAX_SLOTS, MAX_NODES);
        issue_request(scr_pkg::CMD_ATTEMPT, 255, 200);
        issue_request(scr_pkg::CMD_ATTEMPT, 0, 16'hFFFF);
        set_config(8, 1);
        issue_request(scr_pkg::CMD_END_ROUND, 0, 0);
        issue_request(scr_pkg::CMD_RESTART, 0, 0);
    endtask

    task automatic test_config_limits();
        set_config(0, 0);
        issue_request(scr_pkg::CMD_ATTEMPT, 0, 12345);
        issue_request(scr_pkg::CMD_ATTEMPT, 1, 0);
        issue_request(scr_pkg::CMD_END_ROUND, 0, 0);
        set_config(511, 511);
        issue_request(scr_pkg::CMD_ATTEMPT, 255, 16'hFFFF);
        issue_request(scr_pkg::CMD_ATTEMPT, 128, 511);
        issue_request(scr_pkg::CMD_END_ROUND, 0, 0);
        issue_request(scr_pkg::CMD_RESTART, 0, 0);
    endtask

    task automatic test_random_rounds();
        int items;
        int roll;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            set_config(pick_size(MAX_SLOTS), pick_size(MAX_NODES));
            pacing_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 1)
            begin
                issue_request(scr_pkg::CMD_RESTART, $urandom_range(0, 255),
                              $urandom_range(0, 65535));
                items++;
            end
            repeat ($urandom_range(2, 10))
            begin
                repeat ($urandom_range(1, 24))
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 80)
                    begin
                        issue_request(scr_pkg::CMD_ATTEMPT, $urandom_range(eff_nodes() - 1),
                                      $urandom_range(0, 65535));
                        items++;
                    end
                    else if (roll < 92)
                    begin
                        issue_request(scr_pkg::CMD_ATTEMPT, $urandom_range(0, 255),
                                      $urandom_range(0, 65535));
                        items++;
                    end
                    else if (roll < 95)
                    begin
                        issue_request(CMD_UNUSED, $urandom_range(0, 255),
                                      $urandom_range(0, 65535));
                        items++;
                    end
                    else if (roll < 97)
                    begin
                        issue_request(scr_pkg::CMD_RESTART, $urandom_range(0, 255),
                                      $urandom_range(0, 65535));
                        items++;
                    end
                    else if (roll < 99)
                    begin
                        issue_request(scr_pkg::CMD_END_ROUND, $urandom_range(0, 255),
                                      $urandom_range(0, 65535));
                        items++;
                    end
                    else
                        wait_quiet();
                end
                issue_request(scr_pkg::CMD_END_ROUND, $urandom_range(0, 255),
                              $urandom_range(0, 65535));
                items++;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_status();
        test_contention();
        test_window_shrink();
        test_config_limits();
        test_random_rounds();
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_cnt == 0 && expected_outcomes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
